>>> rtl/core/hrdfw_pkg.sv
// Shared constants and types for the hex record deframer and flash writer.
package hrdfw_pkg;

    localparam int MAX_DATA_BYTES = 64;
    localparam int STORE_DEPTH    = MAX_DATA_BYTES + 5;
    localparam int IDX_W          = $clog2(STORE_DEPTH + 1);
    localparam int OUT_BITS       = 52;
    localparam int OUT_W          = ((OUT_BITS + 7) / 8) * 8;

    typedef logic [7:0]       byte_t;
    typedef logic [IDX_W-1:0] idx_t;

    localparam byte_t CH_STX = 8'h02;
    localparam byte_t CH_ETX = 8'h03;
    localparam byte_t CH_DLE = 8'h10;
    localparam byte_t PAD_BYTE = 8'hFF;

    localparam byte_t REC_TYPE_DATA   = 8'h00;
    localparam byte_t REC_TYPE_END    = 8'h01;
    localparam byte_t REC_TYPE_LINEAR = 8'h04;

    localparam logic [1:0] PH_IDLE       = 2'd0;
    localparam logic [1:0] PH_PROCESSING = 2'd1;
    localparam logic [1:0] PH_PROCESSED  = 2'd2;
    localparam logic [1:0] PH_CORRUPT    = 2'd3;

    localparam logic [1:0] RESP_NONE = 2'd0;
    localparam logic [1:0] RESP_ACK  = 2'd1;
    localparam logic [1:0] RESP_CSUM = 2'd2;

endpackage

>>> rtl/core/hex_record_deframer_flash_writer_core.sv
// Top level: byte deframer, record store and halfword write sequencer.
// A non-ETX byte is absorbed when accepted. An ETX enters an evaluation state; each
// halfword write of a good data record takes two reads of the record store's single read
// port, a packing state and the output handshake, followed by the response.
// Throughput: one item at a time; s_tready is low while an ETX burst is being sent.
// Reset (aresetn low, synchronous) clears phase, escape, fill count, checksum, upper
// address and linear mode; the store is gated by the fill count, so no clearing pass.
module hex_record_deframer_flash_writer_core
    import hrdfw_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,   // [7:0] rx_byte
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,   // [0] is_write, [32:1] flash_address,
                                        // [48:33] halfword, [50:49] response,
                                        // [51] end_of_file, rest zero
    output logic             m_tlast
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EVAL  = 3'd1;
    localparam logic [2:0] S_RD_LO = 3'd2;
    localparam logic [2:0] S_RD_HI = 3'd3;
    localparam logic [2:0] S_PACK  = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    localparam idx_t DATA_BASE = idx_t'(4);
    localparam idx_t MAX_LEN   = idx_t'(MAX_DATA_BYTES);

    logic [2:0]  state_reg, state_next;
    logic [1:0]  phase_reg, phase_next;
    logic        esc_reg, esc_next;
    idx_t        count_reg, count_next;
    byte_t       sum_reg, sum_next;
    logic [15:0] upper_reg, upper_next;
    logic        linear_reg, linear_next;

    byte_t       hdr_reg [0:5];
    byte_t       store_mem [0:STORE_DEPTH-1];
    byte_t       rd_data_reg;
    idx_t        rd_addr;
    logic        mem_we;

    idx_t        lo_idx_reg, lo_idx_next;
    logic [31:0] addr_reg, addr_next;
    byte_t       lo_byte_reg, lo_byte_next;

    logic        o_wr_reg, o_wr_next;
    logic [31:0] o_addr_reg, o_addr_next;
    logic [15:0] o_hw_reg, o_hw_next;
    logic [1:0]  o_resp_reg, o_resp_next;
    logic        o_eof_reg, o_eof_next;
    logic        o_last_reg, o_last_next;

    byte_t       h0, h1, h2, h3, h4, h5;
    idx_t        len_eff, end_idx;
    idx_t        hi_idx, lo_idx_step;
    logic [31:0] base_addr;

    // Entries at or past the fill count read as zero.
    assign h0 = (count_reg > idx_t'(0)) ? hdr_reg[0] : 8'h00;
    assign h1 = (count_reg > idx_t'(1)) ? hdr_reg[1] : 8'h00;
    assign h2 = (count_reg > idx_t'(2)) ? hdr_reg[2] : 8'h00;
    assign h3 = (count_reg > idx_t'(3)) ? hdr_reg[3] : 8'h00;
    assign h4 = (count_reg > idx_t'(4)) ? hdr_reg[4] : 8'h00;
    assign h5 = (count_reg > idx_t'(5)) ? hdr_reg[5] : 8'h00;

    assign len_eff     = (h0 > byte_t'(MAX_DATA_BYTES)) ? MAX_LEN : idx_t'(h0);
    assign end_idx     = DATA_BASE + len_eff;
    assign hi_idx      = lo_idx_reg + idx_t'(1);
    assign lo_idx_step = lo_idx_reg + idx_t'(2);
    assign base_addr   = {(linear_reg ? upper_reg : 16'h0000), h1, h2};

    // Substitute the pad byte for an odd length, zero past the fill count.
    function automatic byte_t fix_byte(input idx_t idx, input byte_t raw,
                                       input idx_t cnt, input idx_t len, input idx_t pad);
        byte_t res;
        if (len[0] && idx == pad) begin
            res = PAD_BYTE;
        end else if (idx < cnt) begin
            res = raw;
        end else begin
            res = 8'h00;
        end
        return res;
    endfunction

    always_comb begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        esc_next     = esc_reg;
        count_next   = count_reg;
        sum_next     = sum_reg;
        upper_next   = upper_reg;
        linear_next  = linear_reg;
        lo_idx_next  = lo_idx_reg;
        addr_next    = addr_reg;
        lo_byte_next = lo_byte_reg;
        o_wr_next    = o_wr_reg;
        o_addr_next  = o_addr_reg;
        o_hw_next    = o_hw_reg;
        o_resp_next  = o_resp_reg;
        o_eof_next   = o_eof_reg;
        o_last_next  = o_last_reg;
        mem_we       = 1'b0;
        rd_addr      = lo_idx_reg;

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    if (s_tdata == CH_STX && !esc_reg) begin
                        phase_next = PH_PROCESSING;
                    end else if (s_tdata == CH_ETX && !esc_reg) begin
                        phase_next = PH_PROCESSED;
                        esc_next   = 1'b0;
                        state_next = S_EVAL;
                    end else if (phase_reg == PH_PROCESSING) begin
                        if (s_tdata == CH_DLE && !esc_reg) begin
                            esc_next = 1'b1;
                        end else begin
                            esc_next = 1'b0;
                            if (count_reg < idx_t'(STORE_DEPTH)) begin
                                mem_we     = 1'b1;
                                count_next = count_reg + idx_t'(1);
                                sum_next   = sum_reg + s_tdata;
                            end else begin
                                phase_next = PH_CORRUPT;
                            end
                        end
                    end
                end
            end
            S_EVAL: begin
                o_wr_next   = 1'b0;
                o_addr_next = 32'h0;
                o_hw_next   = 16'h0;
                o_eof_next  = 1'b0;
                o_last_next = 1'b1;
                if (sum_reg != 8'h00) begin
                    o_resp_next = RESP_CSUM;
                    state_next  = S_EMIT;
                end else if (h3 == REC_TYPE_DATA && len_eff != idx_t'(0)) begin
                    lo_idx_next = DATA_BASE;
                    addr_next   = base_addr;
                    state_next  = S_RD_LO;
                end else begin
                    if (h3 == REC_TYPE_LINEAR) begin
                        linear_next = 1'b1;
                        upper_next  = {h4, h5};
                    end
                    o_resp_next = RESP_ACK;
                    o_eof_next  = (h3 == REC_TYPE_END);
                    state_next  = S_EMIT;
                end
            end
            S_RD_LO: begin
                rd_addr    = lo_idx_reg;
                state_next = S_RD_HI;
            end
            S_RD_HI: begin
                rd_addr      = hi_idx;
                lo_byte_next = fix_byte(lo_idx_reg, rd_data_reg, count_reg, len_eff, end_idx);
                state_next   = S_PACK;
            end
            S_PACK: begin
                o_wr_next   = 1'b1;
                o_addr_next = addr_reg;
                o_hw_next   = {fix_byte(hi_idx, rd_data_reg, count_reg, len_eff, end_idx),
                               lo_byte_reg};
                o_resp_next = RESP_NONE;
                o_eof_next  = 1'b0;
                o_last_next = 1'b0;
                state_next  = S_EMIT;
            end
            S_EMIT: begin
                if (m_tready) begin
                    if (o_last_reg) begin
                        // Record done: drop the store contents and checksum.
                        count_next = '0;
                        sum_next   = 8'h00;
                        state_next = S_IDLE;
                    end else if (lo_idx_step < end_idx) begin
                        lo_idx_next = lo_idx_step;
                        addr_next   = addr_reg + 32'd2;
                        state_next  = S_RD_LO;
                    end else begin
                        o_wr_next   = 1'b0;
                        o_addr_next = 32'h0;
                        o_hw_next   = 16'h0;
                        o_resp_next = RESP_ACK;
                        o_eof_next  = 1'b0;
                        o_last_next = 1'b1;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            phase_reg  <= PH_IDLE;
            esc_reg    <= 1'b0;
            count_reg  <= '0;
            sum_reg    <= 8'h00;
            upper_reg  <= 16'h0000;
            linear_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            esc_reg    <= esc_next;
            count_reg  <= count_next;
            sum_reg    <= sum_next;
            upper_reg  <= upper_next;
            linear_reg <= linear_next;
        end
    end

    always_ff @(posedge aclk) begin
        lo_idx_reg  <= lo_idx_next;
        addr_reg    <= addr_next;
        lo_byte_reg <= lo_byte_next;
        o_wr_reg    <= o_wr_next;
        o_addr_reg  <= o_addr_next;
        o_hw_reg    <= o_hw_next;
        o_resp_reg  <= o_resp_next;
        o_eof_reg   <= o_eof_next;
        o_last_reg  <= o_last_next;
        if (mem_we && count_reg < idx_t'(6)) begin
            hdr_reg[count_reg[2:0]] <= s_tdata;
        end
    end

    // Record store: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            store_mem[count_reg] <= s_tdata;
        end
        rd_data_reg <= store_mem[rd_addr];
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_EMIT);
    assign m_tlast  = o_last_reg;
    assign m_tdata  = {{(OUT_W - OUT_BITS){1'b0}}, o_eof_reg, o_resp_reg, o_hw_reg,
                       o_addr_reg, o_wr_reg};

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input accepted while a result is pending");

    a_last_is_resp: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (o_resp_reg != RESP_NONE)) && (m_tlast != o_wr_reg))
        else $error("last flag does not match response");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= idx_t'(STORE_DEPTH))
        else $error("fill count past store depth");

    a_esc_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        esc_reg |-> (phase_reg == PH_PROCESSING))
        else $error("escape pending outside a record");

    a_flush: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> (count_reg == '0 && s_tready))
        else $error("record not cleared after response");

endmodule
